// ===== src/sodt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sodt_pkg: shared widths and types
// Field widths, serial divider sizes and the send-on-delta decision struct.
// ----------------------------------------------------------------------------
package sodt_pkg;

  localparam int TEMP_W  = 15;  // raw temperature, signed hundredths
  localparam int HUM_W   = 14;  // raw humidity, unsigned hundredths
  localparam int OUT_W   = 15;  // stored values after offset
  localparam int WHOLE_W = 9;   // whole-degree value, signed
  localparam int DEV_W   = 9;   // deviation from average
  localparam int TRIG_W  = 10;  // trigger registers
  localparam int DVD_W   = 15;  // divider dividend magnitude
  localparam int DVS_W   = 7;   // divider divisor
  localparam int QD_W    = 8;   // quotient bits produced, one per cycle

  typedef struct packed {
    logic load;  // reference takes the held value
    logic send;  // delta exceeded since last send
  } trig_t;

endpackage
`default_nettype wire

// ===== src/sodt_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sodt_ifs: item channels
// Valid/ready channels for the reading item and the result item.
// ----------------------------------------------------------------------------
interface sodt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sodt_pkg::TEMP_W-1:0]  raw_temperature;
  logic        [sodt_pkg::HUM_W-1:0]   raw_humidity;

  modport source (output valid, output raw_temperature, output raw_humidity, input ready);
  modport sink   (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

interface sodt_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sodt_pkg::OUT_W-1:0]  temperature_out;
  logic signed [sodt_pkg::OUT_W-1:0]  humidity_out;
  logic                               sample_accepted;
  logic        [sodt_pkg::DEV_W-1:0]  deviation;
  logic                               send_temperature;
  logic                               send_humidity;

  modport source (output valid, output temperature_out, output humidity_out,
                  output sample_accepted, output deviation, output send_temperature,
                  output send_humidity, input ready);
  modport sink   (input valid, input temperature_out, input humidity_out,
                  input sample_accepted, input deviation, input send_temperature,
                  input send_humidity, output ready);
endinterface
`default_nettype wire

// ===== src/sodt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sodt_div: bit-serial restoring divider
// One quotient bit per cycle; the dividend magnitude is
// known to give a quotient below 256. Sign applied at the output.
// ----------------------------------------------------------------------------
module sodt_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [sodt_pkg::DVD_W-1:0]          dvd_i,
  input  wire logic [sodt_pkg::DVS_W-1:0]          dvs_i,
  input  wire logic                                neg_i,
  output logic                                     done_o,
  output logic signed [sodt_pkg::WHOLE_W-1:0]      quot_o
);

  localparam int QD_W  = sodt_pkg::QD_W;
  localparam int DVS_W = sodt_pkg::DVS_W;
  localparam int CW    = $clog2(QD_W);
  localparam logic [CW-1:0] LastCnt = CW'(QD_W - 1);

  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [QD_W-1:0]  sh_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             neg_q;

  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   diff;

  assign trial = {rem_q, sh_q[QD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dvd_i[sodt_pkg::DVD_W-1:QD_W];
      sh_q  <= dvd_i[QD_W-1:0];
      dvs_q <= dvs_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      sh_q  <= {sh_q[QD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});

endmodule
`default_nettype wire

// ===== src/sodt_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sodt_ring: window memory
// Single-port store of whole-degree samples with registered read data.
// ----------------------------------------------------------------------------
module sodt_ring #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rd_en_i,
  input  wire logic                                  wr_en_i,
  input  wire logic [AW-1:0]                         addr_i,
  input  wire logic signed [sodt_pkg::WHOLE_W-1:0]   wr_data_i,
  output logic signed [sodt_pkg::WHOLE_W-1:0]        rd_data_o
);

  logic signed [sodt_pkg::WHOLE_W-1:0] mem_q [DEPTH];
  logic signed [sodt_pkg::WHOLE_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

// ===== src/sodt_trig.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sodt_trig: send-on-delta decision
// Compares the held value with the last sent reference against trigger*10.
// ----------------------------------------------------------------------------
module sodt_trig (
  input  wire logic                                en_i,
  input  wire logic signed [sodt_pkg::OUT_W-1:0]   held_i,
  input  wire logic signed [sodt_pkg::OUT_W-1:0]   ref_i,
  input  wire logic                                ref_vld_i,
  input  wire logic [sodt_pkg::TRIG_W-1:0]         trig_i,
  output sodt_pkg::trig_t                          dec_o
);

  localparam int OUT_W = sodt_pkg::OUT_W;
  localparam int THR_W = sodt_pkg::TRIG_W + 4;

  logic signed [OUT_W:0] diff;
  logic        [OUT_W:0] mag;
  logic        [THR_W-1:0] thr;
  logic                  over;

  assign diff = (OUT_W+1)'(held_i) - (OUT_W+1)'(ref_i);
  assign mag  = diff[OUT_W] ? unsigned'(-diff) : unsigned'(diff);
  assign thr  = {1'b0, trig_i, 3'b000} + {3'b000, trig_i, 1'b0};
  assign over = mag > (OUT_W+1)'(thr);

  always_comb begin
    dec_o.load = en_i && (!ref_vld_i || over);
    dec_o.send = en_i && ref_vld_i && over;
  end

endmodule
`default_nettype wire

// ===== src/sensor_outlier_and_delta_trigger_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_outlier_and_delta_trigger_top: outlier filter with send-on-delta
// Offsets readings, keeps a moving average of whole degrees, rejects
// outliers and raises send flags when stored values move past a trigger.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    raw_temperature, raw_humidity
//  out_o    out  valid/ready    temperature_out, humidity_out, sample_accepted,
//                               deviation, send_temperature, send_humidity
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
//  An item passes through S_TQ, S_DIV1, S_UPD, S_ACC, S_DIV2, S_TRG and S_FIN
//  from acceptance to the result register; two divider runs, one for whole
//  degrees and one for the average, set its length.
//  One item is in flight at a time; the next is taken once the result is
//  loaded, even while that result waits on out_o.ready.
//  Reset clears the window sum, average, fill count, slot and all valid flags.
// ----------------------------------------------------------------------------
module sensor_outlier_and_delta_trigger_top #(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i,
  sodt_in_if.sink          in_i,
  sodt_out_if.source       out_o
);

  localparam int AW      = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int WHOLE_W = sodt_pkg::WHOLE_W;
  localparam int SUM_W   = WHOLE_W + $clog2(WINDOW_DEPTH);
  localparam int OUT_W   = sodt_pkg::OUT_W;
  localparam int DEV_W   = sodt_pkg::DEV_W;
  localparam int DvdW    = sodt_pkg::DVD_W;
  localparam int DvsW    = sodt_pkg::DVS_W;
  localparam logic [DvsW-1:0] TempDiv = DvsW'(100);

  typedef enum logic [2:0] {
    CFG_TEMP_OFF = 3'd0,
    CFG_HUM_OFF  = 3'd1,
    CFG_TEMP_TRG = 3'd2,
    CFG_HUM_TRG  = 3'd3,
    CFG_MAX_DEV  = 3'd4,
    CFG_HUM_EN   = 3'd5
  } cfg_idx_e;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TQ   = 8'b0000_0010,
    S_DIV1 = 8'b0000_0100,
    S_UPD  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_DIV2 = 8'b0010_0000,
    S_TRG  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  function automatic logic signed [11:0] times10(input logic signed [7:0] o);
    logic signed [11:0] e;
    e = 12'(o);
    return (e <<< 3) + (e <<< 1);
  endfunction

  function automatic logic signed [14:0] sat15(input logic signed [15:0] v);
    if (v[15] != v[14]) begin
      return v[15] ? {1'b1, 14'd0} : {1'b0, {14{1'b1}}};
    end
    return v[14:0];
  endfunction

  // config
  logic signed [7:0] temp_off_q, hum_off_q;
  logic [9:0]        temp_trg_q, hum_trg_q;
  logic [7:0]        max_dev_q;
  logic              hum_en_q;

  state_e state_q, state_d;

  logic signed [OUT_W-1:0]   t_q;
  logic signed [WHOLE_W-1:0] whole_q;
  logic signed [WHOLE_W-1:0] avg_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]          fill_q;
  logic [AW-1:0]             slot_q;
  logic [DEV_W-1:0]          dev_q;
  logic                      acc_q;
  logic signed [OUT_W-1:0]   held_t_q, held_h_q, tref_q, href_q;
  logic                      held_t_vld_q, held_h_vld_q, tref_vld_q, href_vld_q;
  logic                      send_t_q, send_h_q;

  logic                      out_vld_q;
  logic signed [OUT_W-1:0]   out_t_q, out_h_q;
  logic                      out_acc_q, out_st_q, out_sh_q;
  logic [DEV_W-1:0]          out_dev_q;

  logic                      in_acc;
  logic                      fin_load;
  logic                      full;
  logic signed [OUT_W-1:0]   t_d, h_d;
  logic signed [WHOLE_W-1:0] last;
  logic signed [SUM_W-1:0]   sum_d;
  logic [SUM_W-1:0]          sum_mag;
  logic [OUT_W-1:0]          t_mag;
  logic signed [WHOLE_W:0]   avg_diff;
  logic [WHOLE_W:0]          avg_mag;

  logic                      div_start, div_done, div_neg;
  logic [DvdW-1:0]           div_dvd;
  logic [DvsW-1:0]           div_dvs;
  logic signed [WHOLE_W-1:0] div_quot;

  sodt_pkg::trig_t           tdec, hdec;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = state_q == S_IDLE;
  assign fin_load = (state_q == S_FIN) && (!out_vld_q || out_o.ready);
  assign full     = fill_q == CNT_W'(WINDOW_DEPTH);

  assign t_d = sat15(16'(in_i.raw_temperature) + 16'(times10(temp_off_q)));
  assign h_d = sat15($signed({2'b00, in_i.raw_humidity}) + 16'(times10(hum_off_q)));

  assign sum_d    = sum_q + SUM_W'(whole_q) - (full ? SUM_W'(last) : SUM_W'(0));
  assign sum_mag  = sum_q[SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
  assign t_mag    = t_q[OUT_W-1] ? unsigned'(-t_q) : unsigned'(t_q);
  assign avg_diff = (WHOLE_W+1)'(avg_q) - (WHOLE_W+1)'(whole_q);
  assign avg_mag  = avg_diff[WHOLE_W] ? unsigned'(-avg_diff) : unsigned'(avg_diff);

  // divider operand select: whole degrees first, then the window average
  always_comb begin
    div_start = 1'b0;
    div_dvd   = DvdW'(t_mag);
    div_dvs   = TempDiv;
    div_neg   = t_q[OUT_W-1];
    case (state_q)
      S_TQ: begin
        div_start = 1'b1;
      end
      S_ACC: begin
        div_start = 1'b1;
        div_dvd   = DvdW'(sum_mag);
        div_dvs   = DvsW'(fill_q);
        div_neg   = sum_q[SUM_W-1];
      end
      default: begin
      end
    endcase
  end

  sodt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .neg_i   (div_neg),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  sodt_ring #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .wr_en_i   (state_q == S_UPD),
    .addr_i    (slot_q),
    .wr_data_i (whole_q),
    .rd_data_o (last)
  );

  sodt_trig u_trig_t (
    .en_i      ((temp_trg_q != '0) && held_t_vld_q),
    .held_i    (held_t_q),
    .ref_i     (tref_q),
    .ref_vld_i (tref_vld_q),
    .trig_i    (temp_trg_q),
    .dec_o     (tdec)
  );

  sodt_trig u_trig_h (
    .en_i      (hum_en_q && (hum_trg_q != '0) && held_h_vld_q),
    .held_i    (held_h_q),
    .ref_i     (href_q),
    .ref_vld_i (href_vld_q),
    .trig_i    (hum_trg_q),
    .dec_o     (hdec)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_TQ;
      S_TQ:    state_d = S_DIV1;
      S_DIV1:  if (div_done) state_d = S_UPD;
      S_UPD:   state_d = S_ACC;
      S_ACC:   state_d = S_DIV2;
      S_DIV2:  if (div_done) state_d = S_TRG;
      S_TRG:   state_d = S_FIN;
      S_FIN:   if (fin_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_off_q <= '0;
      hum_off_q  <= '0;
      temp_trg_q <= '0;
      hum_trg_q  <= '0;
      max_dev_q  <= 8'd5;
      hum_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TEMP_OFF: temp_off_q <= cfg_data_i[7:0];
        CFG_HUM_OFF:  hum_off_q  <= cfg_data_i[7:0];
        CFG_TEMP_TRG: temp_trg_q <= cfg_data_i;
        CFG_HUM_TRG:  hum_trg_q  <= cfg_data_i;
        CFG_MAX_DEV:  max_dev_q  <= cfg_data_i[7:0];
        CFG_HUM_EN:   hum_en_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sum_q        <= '0;
      avg_q        <= '0;
      fill_q       <= '0;
      slot_q       <= '0;
      held_t_vld_q <= 1'b0;
      held_h_vld_q <= 1'b0;
      tref_vld_q   <= 1'b0;
      href_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && hum_en_q) begin
        held_h_vld_q <= 1'b1;
      end
      if (state_q == S_UPD) begin
        sum_q <= sum_d;
        if (!full) begin
          fill_q <= fill_q + 1'b1;
        end
        slot_q <= (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
      if ((state_q == S_ACC) && ({1'b0, max_dev_q} > dev_q)) begin
        held_t_vld_q <= 1'b1;
      end
      if ((state_q == S_DIV2) && div_done) begin
        avg_q <= div_quot;
      end
      if ((state_q == S_TRG) && tdec.load) begin
        tref_vld_q <= 1'b1;
      end
      if ((state_q == S_TRG) && hdec.load) begin
        href_vld_q <= 1'b1;
      end
      if (fin_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q <= t_d;
      if (hum_en_q) begin
        held_h_q <= h_d;
      end
    end
    if ((state_q == S_DIV1) && div_done) begin
      whole_q <= div_quot;
    end
    if (state_q == S_UPD) begin
      dev_q <= (fill_q != '0) ? avg_mag[DEV_W-1:0] : '0;
    end
    if (state_q == S_ACC) begin
      acc_q <= {1'b0, max_dev_q} > dev_q;
      if ({1'b0, max_dev_q} > dev_q) begin
        held_t_q <= t_q;
      end
    end
    if (state_q == S_TRG) begin
      send_t_q <= tdec.send;
      send_h_q <= hdec.send;
      if (tdec.load) begin
        tref_q <= held_t_q;
      end
      if (hdec.load) begin
        href_q <= held_h_q;
      end
    end
    if (fin_load) begin
      out_t_q   <= held_t_vld_q ? held_t_q : '0;
      out_h_q   <= held_h_vld_q ? held_h_q : '0;
      out_acc_q <= acc_q;
      out_dev_q <= dev_q;
      out_st_q  <= send_t_q;
      out_sh_q  <= send_h_q;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.temperature_out  = out_t_q;
  assign out_o.humidity_out     = out_h_q;
  assign out_o.sample_accepted  = out_acc_q;
  assign out_o.deviation        = out_dev_q;
  assign out_o.send_temperature = out_st_q;
  assign out_o.send_humidity    = out_sh_q;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sensor outlier filter with send-on-delta
// Drives temperature/humidity readings through the valid/ready channel and
// checks every result item against an in-bench model of the moving-average
// outlier filter and the send-on-delta triggers. Registers are rewritten
// between phases while the block is idle; both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int OUT_W   = sodt_pkg::OUT_W;
  localparam int DEV_W   = sodt_pkg::DEV_W;
  localparam int TRIG_W  = sodt_pkg::TRIG_W;
  localparam int WHOLE_W = sodt_pkg::WHOLE_W;

  localparam int WINDOW_DEPTH = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int TEMP_LO = -5500;
  localparam int TEMP_HI = 12500;
  localparam int HUM_HI  = 10000;

  typedef enum logic [2:0] {
    REG_TEMP_OFFSET,
    REG_HUM_OFFSET,
    REG_TEMP_TRIGGER,
    REG_HUM_TRIGGER,
    REG_MAX_DEVIATION,
    REG_HUMIDITY_ENABLE
  } cfg_reg_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] temperature;
    logic signed [OUT_W-1:0] humidity;
    logic                    accepted;
    logic        [DEV_W-1:0] deviation;
    logic                    send_temperature;
    logic                    send_humidity;
  } reading_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [9:0] cfg_data_i;

  sodt_in_if  in_if ();
  sodt_out_if out_if ();

  sensor_outlier_and_delta_trigger_top #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // register copies
  logic signed [7:0]        temp_offset_q;
  logic signed [7:0]        hum_offset_q;
  logic        [TRIG_W-1:0] temp_trig_q;
  logic        [TRIG_W-1:0] hum_trig_q;
  logic        [7:0]        max_dev_q;
  logic                     hum_enable_q;

  // filter state
  logic signed [WHOLE_W-1:0] win_ring [WINDOW_DEPTH];
  logic signed [15:0]        win_sum;
  logic signed [WHOLE_W-1:0] win_avg;
  logic        [3:0]         fill_cnt;
  logic        [2:0]         win_slot;
  logic signed [OUT_W-1:0]   held_temp, held_hum, temp_ref, hum_ref;
  logic                      held_temp_valid, held_hum_valid;
  logic                      temp_ref_valid, hum_ref_valid;

  reading_result_t expected_results [$];

  int  cycle_count      = 0;
  int  mismatches       = 0;
  int  results_seen     = 0;
  int  readings_sent;
  int  cfg_writes;
  int  rejected_seen    = 0;
  int  sends_seen       = 0;
  int  temp_walk;
  int  hum_walk;
  bit  src_idle_on;
  bit  sink_idle_on;
  int  sink_hold_reqs   = 0;
  int  sink_holds_taken = 0;
  int  sink_hold_left   = 0;
  int  sink_stall_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_range(input int v, input int lo, input int hi);
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  function automatic int abs_diff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic reading_result_t filter_reading(input int raw_t, input int raw_h);
    reading_result_t r;
    int t, whole, dev, leaving;
    bit accepted;
    r = '0;
    t = clamp_range(raw_t + 10 * int'(temp_offset_q), -16384, 16383);
    if (hum_enable_q) begin
      held_hum       = OUT_W'(clamp_range(raw_h + 10 * int'(hum_offset_q), -16384, 16383));
      held_hum_valid = 1'b1;
    end
    whole   = t / 100;
    dev     = (fill_cnt != 0) ? abs_diff(int'(win_avg), whole) : 0;
    leaving = (fill_cnt >= WINDOW_DEPTH) ? int'(win_ring[win_slot]) : 0;
    win_ring[win_slot] = WHOLE_W'(whole);
    if (fill_cnt < WINDOW_DEPTH) begin
      win_sum  = 16'(int'(win_sum) + whole);
      win_avg  = WHOLE_W'(int'(win_sum) / (int'(fill_cnt) + 1));
      fill_cnt = fill_cnt + 4'd1;
    end else begin
      win_sum = 16'(int'(win_sum) + whole - leaving);
      win_avg = WHOLE_W'(int'(win_sum) / WINDOW_DEPTH);
    end
    win_slot = 3'((int'(win_slot) + 1) % WINDOW_DEPTH);

    accepted = dev < int'(max_dev_q);
    if (accepted) begin
      held_temp       = OUT_W'(t);
      held_temp_valid = 1'b1;
    end

    if (temp_trig_q != 0 && held_temp_valid) begin
      if (!temp_ref_valid) begin
        temp_ref       = held_temp;
        temp_ref_valid = 1'b1;
      end else if (abs_diff(held_temp, temp_ref) > 10 * int'(temp_trig_q)) begin
        temp_ref           = held_temp;
        r.send_temperature = 1'b1;
      end
    end

    if (hum_enable_q && hum_trig_q != 0 && held_hum_valid) begin
      if (!hum_ref_valid) begin
        hum_ref       = held_hum;
        hum_ref_valid = 1'b1;
      end else if (abs_diff(held_hum, hum_ref) > 10 * int'(hum_trig_q)) begin
        hum_ref         = held_hum;
        r.send_humidity = 1'b1;
      end
    end

    r.temperature = held_temp_valid ? held_temp : '0;
    r.humidity    = held_hum_valid ? held_hum : '0;
    r.accepted    = accepted;
    r.deviation   = dev[DEV_W-1:0];
    return r;
  endfunction

  // one reading item; returns at the falling edge after acceptance, valid left high
  task automatic send_reading(input int t, input int h);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.raw_temperature <= 15'(t);
    in_if.raw_humidity    <= 14'(h);
    do @(posedge clk_i); while (!in_if.ready);
    expected_results.push_back(filter_reading(t, h));
    readings_sent++;
    @(negedge clk_i);
  endtask

  // registers change only with nothing in flight
  task automatic write_register(input cfg_reg_e idx, input int value);
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 10'(value);
    case (idx)
      REG_TEMP_OFFSET:     temp_offset_q = 8'(value);
      REG_HUM_OFFSET:      hum_offset_q  = 8'(value);
      REG_TEMP_TRIGGER:    temp_trig_q   = 10'(value);
      REG_HUM_TRIGGER:     hum_trig_q    = 10'(value);
      REG_MAX_DEVIATION:   max_dev_q     = 8'(value);
      REG_HUMIDITY_ENABLE: hum_enable_q  = value[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input int toff, input int hoff, input int ttrig,
                            input int htrig, input int maxdev, input int hen);
    write_register(REG_TEMP_OFFSET, toff);
    write_register(REG_HUM_OFFSET, hoff);
    write_register(REG_TEMP_TRIGGER, ttrig);
    write_register(REG_HUM_TRIGGER, htrig);
    write_register(REG_MAX_DEVIATION, maxdev);
    write_register(REG_HUMIDITY_ENABLE, hen);
  endtask

  // zero max deviation before anything is stored: all rejected, outputs zero
  task automatic test_no_valid_temperature();
    write_register(REG_MAX_DEVIATION, 0);
    write_register(REG_TEMP_TRIGGER, 3);
    send_reading(2000, 0);
    send_reading(TEMP_LO, HUM_HI);
    send_reading(TEMP_HI, 5000);
  endtask

  // warm-up average, outliers at both field extremes, ring wrap
  task automatic test_warmup_average();
    write_register(REG_MAX_DEVIATION, 5);
    send_reading(2000, 100);
    send_reading(2199, 100);
    send_reading(TEMP_HI, 100);
    send_reading(TEMP_LO, 100);
    send_reading(2350, 100);
    send_reading(1999, 100);
    send_reading(2100, 100);
    send_reading(2201, 100);
    send_reading(2250, 100);
    send_reading(2010, 100);
  endtask

  // exactly the trigger span does not send, one more does
  task automatic test_temp_trigger_threshold();
    int base;
    write_register(REG_TEMP_TRIGGER, 5);
    base = int'(temp_ref);
    send_reading(base + 50, 0);
    send_reading(base + 51, 0);
  endtask

  task automatic test_humidity_channel();
    write_register(REG_HUM_OFFSET, -128);
    write_register(REG_HUM_TRIGGER, 1);
    write_register(REG_HUMIDITY_ENABLE, 1);
    send_reading(2050, 0);
    send_reading(2050, HUM_HI);
    write_register(REG_HUM_TRIGGER, 5);
    send_reading(2050, HUM_HI - 50);
    send_reading(2050, HUM_HI - 51);
    write_register(REG_HUMIDITY_ENABLE, 0);
    send_reading(2050, 0);
  endtask

  // drifting readings with occasional outliers and humidity jumps
  task automatic test_random_readings(input int count);
    int t, h;
    for (int i = 0; i < count; i++) begin
      temp_walk = clamp_range(temp_walk + int'($urandom_range(0, 300)) - 150, TEMP_LO, TEMP_HI);
      hum_walk  = clamp_range(hum_walk + int'($urandom_range(0, 400)) - 200, 0, HUM_HI);
      if ($urandom_range(0, 99) < 12)
        t = int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO;
      else
        t = clamp_range(temp_walk + int'($urandom_range(0, 40)) - 20, TEMP_LO, TEMP_HI);
      if ($urandom_range(0, 9) == 0)
        h = int'($urandom_range(0, HUM_HI));
      else
        h = hum_walk;
      send_reading(t, h);
    end
  endtask

  // long receiver hold-off while readings keep coming
  task automatic test_result_backpressure();
    sink_hold_reqs++;
    test_random_readings(30);
  endtask

  // result ready: random stall bursts plus the long hold-off
  always @(negedge clk_i) begin
    if (sink_hold_reqs != sink_holds_taken) begin
      sink_holds_taken = sink_hold_reqs;
      sink_hold_left   = SINK_HOLD_CYCLES;
    end
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      out_if.ready <= 1'b0;
    end else if (sink_stall_left > 0) begin
      sink_stall_left--;
      out_if.ready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      sink_stall_left = int'($urandom_range(1, 10)) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    reading_result_t seen, want;
    bit bad;
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.temperature      = out_if.temperature_out;
      seen.humidity         = out_if.humidity_out;
      seen.accepted         = out_if.sample_accepted;
      seen.deviation        = out_if.deviation;
      seen.send_temperature = out_if.send_temperature;
      seen.send_humidity    = out_if.send_humidity;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: temp %0d hum %0d acc %0b dev %0d",
                   seen.temperature, seen.humidity, seen.accepted, seen.deviation);
      end else begin
        want = expected_results.pop_front();
        bad  = (seen.temperature !== want.temperature) || (seen.humidity !== want.humidity) ||
               (seen.accepted !== want.accepted) || (seen.deviation !== want.deviation) ||
               (seen.send_temperature !== want.send_temperature) ||
               (seen.send_humidity !== want.send_humidity);
        if (!want.accepted) rejected_seen++;
        sends_seen += int'(want.send_temperature) + int'(want.send_humidity);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d:", results_seen);
            $display("  exp temp %0d hum %0d acc %0b dev %0d send_t %0b send_h %0b",
                     want.temperature, want.humidity, want.accepted, want.deviation,
                     want.send_temperature, want.send_humidity);
            $display("  got temp %0d hum %0d acc %0b dev %0d send_t %0b send_h %0b",
                     seen.temperature, seen.humidity, seen.accepted, seen.deviation,
                     seen.send_temperature, seen.send_humidity);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_data_i            = '0;
    in_if.valid           = 1'b0;
    in_if.raw_temperature = '0;
    in_if.raw_humidity    = '0;
    temp_offset_q   = '0;
    hum_offset_q    = '0;
    temp_trig_q     = '0;
    hum_trig_q      = '0;
    max_dev_q       = 8'd5;
    hum_enable_q    = 1'b0;
    foreach (win_ring[i]) win_ring[i] = '0;
    win_sum         = '0;
    win_avg         = '0;
    fill_cnt        = '0;
    win_slot        = '0;
    held_temp       = '0;
    held_hum        = '0;
    temp_ref        = '0;
    hum_ref         = '0;
    held_temp_valid = 1'b0;
    held_hum_valid  = 1'b0;
    temp_ref_valid  = 1'b0;
    hum_ref_valid   = 1'b0;
    readings_sent   = 0;
    cfg_writes      = 0;
    temp_walk       = 2200;
    hum_walk        = 5000;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_no_valid_temperature();
    test_warmup_average();
    test_temp_trigger_threshold();
    test_humidity_channel();

    set_config(0, 0, 1, 1, 255, 1);
    test_random_readings(70);

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b0;
    set_config(-128, 127, 1023, 1023, 5, 1);
    test_random_readings(70);

    src_idle_on  = 1'b0;
    sink_idle_on = 1'b1;
    set_config(127, -128, 20, 30, 3, 0);
    test_random_readings(70);

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    set_config(int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
               $urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(1, 40), 1);
    test_random_readings(70);

    test_result_backpressure();

    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_config(0, 0, 2, 3, 8, 1);
    test_random_readings(70);

    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d readings sent, %0d results checked, %0d register writes",
             readings_sent, results_seen, cfg_writes);
    $display("%0d readings rejected as outliers, %0d send flags, %0d mismatches",
             rejected_seen, sends_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
